// ===== rtl/aewc_pkg.sv =====
// Shared types and constants of the expert activation window counter.
// Used by every module of the block but aewc_ram; depends on nothing.
`timescale 1ns / 1ps

package aewc_pkg;

  // Sizing of the counter store
  localparam int unsigned NUM_LAYERS  = 64;
  localparam int unsigned MAX_EXPERTS = 256;
  localparam int unsigned ROUTE_SLOTS = 8;
  localparam int unsigned ENTRIES     = NUM_LAYERS * MAX_EXPERTS;

  localparam int unsigned LAYER_W    = $clog2(NUM_LAYERS);
  localparam int unsigned EXP_W      = $clog2(MAX_EXPERTS);
  localparam int unsigned ADDR_W     = $clog2(ENTRIES);
  localparam int unsigned SLOT_W     = (ROUTE_SLOTS > 1) ? $clog2(ROUTE_SLOTS) : 1;
  localparam int unsigned SLOT_CNT_W = $clog2(ROUTE_SLOTS + 1);

  // Fixed field widths
  localparam int unsigned MODE_W     = 2;
  localparam int unsigned SLOTS_IN_W = 4;
  localparam int unsigned ID_W       = 10;
  localparam int unsigned RUN_W      = 40;
  localparam int unsigned WIN_W      = 32;
  localparam int unsigned TOK_W      = 16;
  localparam int unsigned WNUM_W     = 16;
  localparam int unsigned NEXP_W     = 9;
  localparam int unsigned EPOCH_W    = 16;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_W      = 16;
  localparam logic [NEXP_W-1:0] NEXP_RESET = NEXP_W'(256);
  localparam logic [TOK_W-1:0]  WLIM_RESET = TOK_W'(2048);

  // Window epochs: the first epoch after a sweep, and the one that forces a
  // renormalising sweep before the tag could wrap
  localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);
  localparam logic [EPOCH_W-1:0] EPOCH_LAST  = {EPOCH_W{1'b1}};

  localparam int unsigned FIFO_DEPTH = 2;

  typedef enum logic [MODE_W-1:0] {
    MODE_RECORD = 2'd0,
    MODE_READ   = 2'd1,
    MODE_CLEAR  = 2'd2
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NUM_EXPERTS  = 1'b0,
    CFG_WINDOW_LIMIT = 1'b1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    CMD_RECORD,
    CMD_READ,
    CMD_CLEAR,
    CMD_NOP
  } cmd_op_e;

  typedef logic [ROUTE_SLOTS-1:0][ID_W-1:0] id_vec_t;

  // Classified item, front to back
  typedef struct packed {
    cmd_op_e                          op;
    logic                             read_ok;
    logic [LAYER_W-1:0]               layer;
    logic [EXP_W-1:0]                 read_expert;
    logic [SLOT_CNT_W-1:0]            nslots;
    logic [ROUTE_SLOTS-1:0]           mask;
    logic [ROUTE_SLOTS-1:0][EXP_W-1:0] ids;
    logic                             closed;
    logic [WNUM_W-1:0]                win_num;
    logic [TOK_W-1:0]                 tokens;
  } cmd_t;

  // One counter entry: window counts are tagged with the epoch they belong to
  typedef struct packed {
    logic [RUN_W-1:0]   run;
    logic [WIN_W-1:0]   win;
    logic [WIN_W-1:0]   prev;
    logic [EPOCH_W-1:0] epoch;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  // Result fields, back to top
  typedef struct packed {
    logic [RUN_W-1:0]  total;
    logic [WIN_W-1:0]  win;
    logic [WIN_W-1:0]  prev;
    logic              closed;
    logic [WNUM_W-1:0] win_num;
    logic [TOK_W-1:0]  tokens;
  } res_t;

endpackage

// ===== rtl/expert_activation_window_counter.sv =====
// Top level of the expert activation window counter: front end, command
// queue and back end. Depends on aewc_pkg, aewc_front, aewc_fifo, aewc_back.
`timescale 1ns / 1ps

// An item is taken when start_i is high and busy_o is low; each item yields
// exactly one result, shown for one cycle with done_o high, and the receiver
// cannot hold it off. A two-deep command queue sits between front and back,
// so up to two items can be taken while the back end is still working. In
// the back end a record item does one counter-memory read-modify-write for
// each valid slot among the first slots_used, capped at eight, pipelined
// through the single read and single write port of the counter memory. A
// read is a single counter-memory read. A clear is a clearing pass over all
// 16384 entries; reset starts the same pass, and busy_o stays high after
// reset until it ends. Window close is instant through an epoch tag in each
// entry; every 65534 closed windows the tags are rebased by a pass over all
// entries, which holds the back end and so can fill the queue.
module expert_activation_window_counter import aewc_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_W-1:0]      cfg_wdata_i,
  input  logic                  start_i,
  output logic                  busy_o,
  input  logic [MODE_W-1:0]     mode_i,
  input  logic [LAYER_W-1:0]    layer_i,
  input  logic [SLOTS_IN_W-1:0] slots_used_i,
  input  logic [ID_W-1:0]       expert_id_0_i,
  input  logic [ID_W-1:0]       expert_id_1_i,
  input  logic [ID_W-1:0]       expert_id_2_i,
  input  logic [ID_W-1:0]       expert_id_3_i,
  input  logic [ID_W-1:0]       expert_id_4_i,
  input  logic [ID_W-1:0]       expert_id_5_i,
  input  logic [ID_W-1:0]       expert_id_6_i,
  input  logic [ID_W-1:0]       expert_id_7_i,
  input  logic [EXP_W-1:0]      read_expert_i,
  output logic                  done_o,
  output logic [RUN_W-1:0]      total_count_o,
  output logic [WIN_W-1:0]      window_count_o,
  output logic [WIN_W-1:0]      previous_window_count_o,
  output logic                  window_closed_o,
  output logic [WNUM_W-1:0]     window_number_o,
  output logic [TOK_W-1:0]      tokens_in_window_o
);

  logic    accept;
  id_vec_t ids;
  cmd_t    front_cmd;
  cmd_t    fifo_cmd;
  logic    fifo_full;
  logic    fifo_empty;
  logic    fifo_pop;
  logic    init_busy;
  res_t    res;

  assign ids[0] = expert_id_0_i;
  assign ids[1] = expert_id_1_i;
  assign ids[2] = expert_id_2_i;
  assign ids[3] = expert_id_3_i;
  assign ids[4] = expert_id_4_i;
  assign ids[5] = expert_id_5_i;
  assign ids[6] = expert_id_6_i;
  assign ids[7] = expert_id_7_i;

  // Input transfer
  assign busy_o = fifo_full || init_busy;
  assign accept = start_i && !busy_o;

  aewc_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .accept_i      (accept),
    .mode_i        (mode_i),
    .layer_i       (layer_i),
    .slots_used_i  (slots_used_i),
    .expert_id_i   (ids),
    .read_expert_i (read_expert_i),
    .cmd_o         (front_cmd)
  );

  aewc_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept),
    .data_i  (front_cmd),
    .full_o  (fifo_full),
    .pop_i   (fifo_pop),
    .empty_o (fifo_empty),
    .data_o  (fifo_cmd)
  );

  aewc_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fifo_empty_i (fifo_empty),
    .fifo_data_i  (fifo_cmd),
    .fifo_pop_o   (fifo_pop),
    .init_busy_o  (init_busy),
    .done_o       (done_o),
    .res_o        (res)
  );

  assign total_count_o           = res.total;
  assign window_count_o          = res.win;
  assign previous_window_count_o = res.prev;
  assign window_closed_o         = res.closed;
  assign window_number_o         = res.win_num;
  assign tokens_in_window_o      = res.tokens;

`ifndef NO_ASSERTIONS
  // The back end only takes a command that is queued
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fifo_pop |-> !fifo_empty)
    else $error("command popped from empty queue");

  // A result that closes a window carries no counts and an empty window
  a_closed_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && window_closed_o) |->
      (total_count_o == '0) && (window_count_o == '0) &&
      (previous_window_count_o == '0) && (tokens_in_window_o == '0))
    else $error("window close result carries counts");

  // No result leaves during the clearing pass after reset
  a_init_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    init_busy |-> !done_o)
    else $error("result during initial clearing pass");
`endif

endmodule

// ===== rtl/aewc_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. No dependencies.
`timescale 1ns / 1ps

module aewc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                         wdata_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // A read at the written address returns the old contents
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/aewc_front.sv =====
// Front end: configuration registers, item classification and the token
// window bookkeeping. Depends on aewc_pkg.
`timescale 1ns / 1ps

module aewc_front import aewc_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_W-1:0]      cfg_wdata_i,
  input  logic                  accept_i,
  input  logic [MODE_W-1:0]     mode_i,
  input  logic [LAYER_W-1:0]    layer_i,
  input  logic [SLOTS_IN_W-1:0] slots_used_i,
  input  id_vec_t               expert_id_i,
  input  logic [EXP_W-1:0]      read_expert_i,
  output cmd_t                  cmd_o
);

  logic [NEXP_W-1:0]     nexp_q;
  logic [TOK_W-1:0]      wlim_q;
  logic [LAYER_W-1:0]    lowest_q, lowest_d;
  logic                  seen_q, seen_d;
  logic [TOK_W-1:0]      tok_q, tok_d;
  logic [WNUM_W-1:0]     wins_q, wins_d;

  logic [NEXP_W-1:0]     lim;
  logic [SLOT_CNT_W-1:0] nslots;
  logic                  layer_ok;
  logic [TOK_W-1:0]      tok_inc;
  logic                  closed;
  cmd_op_e               op;
  logic [ROUTE_SLOTS-1:0]            slot_mask;
  logic [ROUTE_SLOTS-1:0][EXP_W-1:0] slot_ids;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nexp_q <= NEXP_RESET;
      wlim_q <= WLIM_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_NUM_EXPERTS:  nexp_q <= cfg_wdata_i[NEXP_W-1:0];
        CFG_WINDOW_LIMIT: wlim_q <= cfg_wdata_i[TOK_W-1:0];
      endcase
    end
  end

  // Slot count and id limit
  assign nslots = (slots_used_i > SLOTS_IN_W'(ROUTE_SLOTS)) ? SLOT_CNT_W'(ROUTE_SLOTS)
                                                            : SLOT_CNT_W'(slots_used_i);
  assign lim    = (nexp_q > NEXP_W'(MAX_EXPERTS)) ? NEXP_W'(MAX_EXPERTS) : nexp_q;
  assign layer_ok = int'(layer_i) < NUM_LAYERS;

  // Per-slot validity: in range of slots_used, not negative, below the limit
  always_comb begin
    for (int s = 0; s < ROUTE_SLOTS; s++) begin
      slot_mask[s] = (SLOT_CNT_W'(s) < nslots) && !expert_id_i[s][ID_W-1] &&
                     (expert_id_i[s][ID_W-2:0] < lim);
      slot_ids[s]  = expert_id_i[s][EXP_W-1:0];
    end
  end

  // Window bookkeeping and classification
  always_comb begin
    lowest_d = lowest_q;
    seen_d   = seen_q;
    tok_d    = tok_q;
    wins_d   = wins_q;
    tok_inc  = tok_q + TOK_W'(1);
    closed   = 1'b0;
    op       = CMD_NOP;
    unique case (mode_e'(mode_i))
      MODE_RECORD: begin
        if (layer_ok) begin
          op = CMD_RECORD;
          if (!seen_q || (layer_i < lowest_q)) begin
            lowest_d = layer_i;
          end
          seen_d = 1'b1;
          if (layer_i == lowest_d) begin
            if (tok_inc >= wlim_q) begin
              closed = 1'b1;
              tok_d  = '0;
              wins_d = wins_q + WNUM_W'(1);
            end else begin
              tok_d = tok_inc;
            end
          end
        end
      end
      MODE_READ: begin
        op = CMD_READ;
      end
      MODE_CLEAR: begin
        op       = CMD_CLEAR;
        lowest_d = '0;
        seen_d   = 1'b0;
        tok_d    = '0;
        wins_d   = '0;
      end
      default: begin
        op = CMD_NOP;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lowest_q <= '0;
      seen_q   <= 1'b0;
      tok_q    <= '0;
      wins_q   <= '0;
    end else if (accept_i) begin
      lowest_q <= lowest_d;
      seen_q   <= seen_d;
      tok_q    <= tok_d;
      wins_q   <= wins_d;
    end
  end

  assign cmd_o.op          = op;
  assign cmd_o.read_ok     = layer_ok && (int'(read_expert_i) < MAX_EXPERTS);
  assign cmd_o.layer       = layer_i;
  assign cmd_o.read_expert = read_expert_i;
  assign cmd_o.nslots      = nslots;
  assign cmd_o.mask        = slot_mask;
  assign cmd_o.ids         = slot_ids;
  assign cmd_o.closed      = closed;
  assign cmd_o.win_num     = wins_d;
  assign cmd_o.tokens      = tok_d;

endmodule

// ===== rtl/aewc_fifo.sv =====
// Short command queue between front and back end.
// Depends on aewc_pkg for the command type and depth.
`timescale 1ns / 1ps

module aewc_fifo import aewc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t data_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output cmd_t data_o
);

  localparam int unsigned PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(FIFO_DEPTH + 1);

  cmd_t             mem_q [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] cnt_q;

  // Storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

  assign full_o  = (cnt_q == CNT_W'(FIFO_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_ptr_q];

endmodule

// ===== rtl/aewc_back.sv =====
// Back end: counter memory, read-modify-write pipeline with forwarding,
// clearing and epoch renormalising sweeps. Depends on aewc_pkg, aewc_ram.
`timescale 1ns / 1ps

module aewc_back import aewc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic fifo_empty_i,
  input  cmd_t fifo_data_i,
  output logic fifo_pop_o,
  output logic init_busy_o,
  output logic done_o,
  output res_t res_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SLOT,
    ST_DRAIN,
    ST_RDWAIT,
    ST_SWEEP,
    ST_SWEEP_END
  } state_e;

  typedef enum logic [1:0] {
    EX_BUMP,
    EX_NORM,
    EX_ZERO,
    EX_READ
  } ex_op_e;

  state_e              state_q, state_d;
  cmd_t                cmd_q, cmd_d;
  logic [SLOT_W-1:0]   slot_q, slot_d;
  logic [ADDR_W-1:0]   sweep_q, sweep_d;
  logic                sweep_zero_q, sweep_zero_d;
  logic                init_q, init_d;
  logic [EPOCH_W-1:0]  epoch_q, epoch_d;
  logic                ex_v_q, ex_v_d;
  ex_op_e              ex_op_q, ex_op_d;
  logic [ADDR_W-1:0]   ex_addr_q, ex_addr_d;
  logic                fwd_v_q;
  logic [ADDR_W-1:0]   fwd_addr_q;
  entry_t              fwd_data_q;
  logic                done_q, done_d;
  res_t                res_q, res_d;

  logic [ADDR_W-1:0]   issue_addr;
  logic                ram_we;
  entry_t              ram_wdata;
  logic [ENTRY_W-1:0]  ram_rdata;
  entry_t              ent_raw;
  logic [WIN_W-1:0]    ent_cur, ent_prv;
  logic [RUN_W-1:0]    run_inc;
  logic [WIN_W-1:0]    cur_inc;
  logic                fifo_pop;

  aewc_ram #(
    .Width (ENTRY_W),
    .Depth (ENTRIES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ex_addr_q),
    .wdata_i (ram_wdata),
    .raddr_i (issue_addr),
    .rdata_o (ram_rdata)
  );

  // Execute stage: forward the write of the previous cycle, then decode the
  // epoch tag into current and previous window counts
  always_comb begin
    ent_raw = (fwd_v_q && (fwd_addr_q == ex_addr_q)) ? fwd_data_q : entry_t'(ram_rdata);
    if (ent_raw.epoch == epoch_q) begin
      ent_cur = ent_raw.win;
      ent_prv = ent_raw.prev;
    end else if (ent_raw.epoch == (epoch_q - EPOCH_W'(1))) begin
      ent_cur = '0;
      ent_prv = ent_raw.win;
    end else begin
      ent_cur = '0;
      ent_prv = '0;
    end
    run_inc = (&ent_raw.run) ? ent_raw.run : ent_raw.run + RUN_W'(1);
    cur_inc = (&ent_cur) ? ent_cur : ent_cur + WIN_W'(1);

    ram_wdata = ent_raw;
    unique case (ex_op_q)
      EX_BUMP: begin
        ram_wdata.run   = run_inc;
        ram_wdata.win   = cur_inc;
        ram_wdata.prev  = ent_prv;
        ram_wdata.epoch = epoch_q;
      end
      EX_NORM: begin
        // Rebase onto the first epoch, keeping what the entry means now
        ram_wdata.win   = ent_cur;
        ram_wdata.prev  = ent_prv;
        ram_wdata.epoch = EPOCH_FIRST;
      end
      EX_ZERO: begin
        ram_wdata = '0;
      end
      EX_READ: begin
        ram_wdata = ent_raw;
      end
    endcase
    ram_we = ex_v_q && (ex_op_q != EX_READ);
  end

  // Sequencer: issue stage and result generation
  always_comb begin
    state_d      = state_q;
    cmd_d        = cmd_q;
    slot_d       = slot_q;
    sweep_d      = sweep_q;
    sweep_zero_d = sweep_zero_q;
    init_d       = init_q;
    epoch_d      = epoch_q;
    ex_v_d       = 1'b0;
    ex_op_d      = ex_op_q;
    ex_addr_d    = ex_addr_q;
    issue_addr   = ex_addr_q;
    fifo_pop     = 1'b0;
    done_d       = 1'b0;
    res_d        = res_q;

    unique case (state_q)
      ST_IDLE: begin
        if (!fifo_empty_i) begin
          fifo_pop      = 1'b1;
          cmd_d         = fifo_data_i;
          res_d.total   = '0;
          res_d.win     = '0;
          res_d.prev    = '0;
          res_d.closed  = 1'b0;
          res_d.win_num = fifo_data_i.win_num;
          res_d.tokens  = fifo_data_i.tokens;
          unique case (fifo_data_i.op)
            CMD_RECORD: begin
              slot_d  = '0;
              state_d = (fifo_data_i.nslots == '0) ? ST_DRAIN : ST_SLOT;
            end
            CMD_READ: begin
              issue_addr = {fifo_data_i.layer, fifo_data_i.read_expert};
              ex_v_d     = 1'b1;
              ex_op_d    = EX_READ;
              ex_addr_d  = issue_addr;
              state_d    = ST_RDWAIT;
            end
            CMD_CLEAR: begin
              done_d       = 1'b1;
              sweep_d      = '0;
              sweep_zero_d = 1'b1;
              state_d      = ST_SWEEP;
            end
            CMD_NOP: begin
              done_d = 1'b1;
            end
          endcase
        end
      end
      ST_SLOT: begin
        // One slot a cycle; masked slots leave a bubble
        if (cmd_q.mask[slot_q]) begin
          issue_addr = {cmd_q.layer, cmd_q.ids[slot_q]};
          ex_v_d     = 1'b1;
          ex_op_d    = EX_BUMP;
          ex_addr_d  = issue_addr;
        end
        if (SLOT_CNT_W'(slot_q) == (cmd_q.nslots - SLOT_CNT_W'(1))) begin
          state_d = ST_DRAIN;
        end else begin
          slot_d = slot_q + SLOT_W'(1);
        end
      end
      ST_DRAIN: begin
        // Last increment, if any, retires this cycle; then the window may close
        done_d       = 1'b1;
        res_d.closed = cmd_q.closed;
        state_d      = ST_IDLE;
        if (cmd_q.closed) begin
          epoch_d = epoch_q + EPOCH_W'(1);
          if ((epoch_q + EPOCH_W'(1)) == EPOCH_LAST) begin
            sweep_d      = '0;
            sweep_zero_d = 1'b0;
            state_d      = ST_SWEEP;
          end
        end
      end
      ST_RDWAIT: begin
        done_d  = 1'b1;
        state_d = ST_IDLE;
        if (cmd_q.read_ok) begin
          res_d.total = ent_raw.run;
          res_d.win   = ent_cur;
          res_d.prev  = ent_prv;
        end
      end
      ST_SWEEP: begin
        issue_addr = sweep_q;
        ex_v_d     = 1'b1;
        ex_op_d    = sweep_zero_q ? EX_ZERO : EX_NORM;
        ex_addr_d  = sweep_q;
        if (sweep_q == ADDR_W'(ENTRIES - 1)) begin
          state_d = ST_SWEEP_END;
        end else begin
          sweep_d = sweep_q + ADDR_W'(1);
        end
      end
      ST_SWEEP_END: begin
        epoch_d = EPOCH_FIRST;
        init_d  = 1'b0;
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State, pipeline and registered outputs; reset starts the clearing sweep
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_SWEEP;
      cmd_q        <= '0;
      slot_q       <= '0;
      sweep_q      <= '0;
      sweep_zero_q <= 1'b1;
      init_q       <= 1'b1;
      epoch_q      <= EPOCH_FIRST;
      ex_v_q       <= 1'b0;
      ex_op_q      <= EX_READ;
      ex_addr_q    <= '0;
      fwd_v_q      <= 1'b0;
      fwd_addr_q   <= '0;
      fwd_data_q   <= '0;
      done_q       <= 1'b0;
      res_q        <= '0;
    end else begin
      state_q      <= state_d;
      cmd_q        <= cmd_d;
      slot_q       <= slot_d;
      sweep_q      <= sweep_d;
      sweep_zero_q <= sweep_zero_d;
      init_q       <= init_d;
      epoch_q      <= epoch_d;
      ex_v_q       <= ex_v_d;
      ex_op_q      <= ex_op_d;
      ex_addr_q    <= ex_addr_d;
      fwd_v_q      <= ram_we;
      fwd_addr_q   <= ex_addr_q;
      fwd_data_q   <= ram_wdata;
      done_q       <= done_d;
      res_q        <= res_d;
    end
  end

  assign fifo_pop_o  = fifo_pop;
  assign init_busy_o = init_q;
  assign done_o      = done_q;
  assign res_o       = res_q;

endmodule
